// ----- design/cce_pkg.sv -----
// ----------------------------------------------------------------------------
// Cubic curve evaluator package
// Shared widths, curve kind codes, coefficient types and the basis matrices.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam int CTRL_W    = 32;
    localparam int T_IN_W    = 17;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 32;
    localparam int COEF_W    = 36;
    localparam int ACC_W     = 39;
    localparam int U_W       = ACC_W + 1;

    // divide by three: the biased dividend is split into two halves
    localparam int U_LO_W  = 20;
    localparam int U_HI_W  = U_W - U_LO_W;
    localparam int HI_SH   = U_HI_W + 2;
    localparam int MH_W    = 2 * U_HI_W + 1;
    localparam int QH_W    = MH_W - HI_SH;
    localparam int V_W     = U_LO_W + 2;
    localparam int LO_SH   = V_W + 2;
    localparam int ML_W    = 2 * V_W + 1;
    localparam int QL_W    = ML_W - LO_SH;

    localparam logic [U_HI_W:0] HI_RECIP = 21'd1398102;
    localparam logic [V_W:0]    LO_RECIP = 23'd5592406;

    localparam logic [U_W-1:0]        DIV3_BIAS   = 40'hC0_0000_0000;
    localparam logic signed [U_W-1:0] DIV3_OFFSET = 40'sh40_0000_0000;
    localparam logic signed [U_W-1:0] SAT_MAX     = 40'sh00_7FFF_FFFF;
    localparam logic signed [U_W-1:0] SAT_MIN     = 40'shFF_8000_0000;

    typedef enum logic [1:0] {
        FUNC_BSPLINE     = 2'd0,
        FUNC_CATMULL_ROM = 2'd1,
        FUNC_BEZIER      = 2'd2,
        FUNC_TANGENT     = 2'd3
    } func_t;

    typedef logic signed [CTRL_W-1:0] ctrl_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // k0 multiplies t^3, k3 is the constant term
    typedef struct packed {
        coef_t k0;
        coef_t k1;
        coef_t k2;
        coef_t k3;
    } coefs_t;

    typedef struct packed {
        coefs_t coefs;
        func_t  func;
    } side_t;

    function automatic coefs_t curve_coefs(input func_t func, input ctrl_t c0,
                                           input ctrl_t c1, input ctrl_t c2,
                                           input ctrl_t c3);
        coef_t  e0;
        coef_t  e1;
        coef_t  e2;
        coef_t  e3;
        coef_t  cubic;
        coefs_t k;
        e0 = COEF_W'(c0);
        e1 = COEF_W'(c1);
        e2 = COEF_W'(c2);
        e3 = COEF_W'(c3);
        cubic = -e0 + 36'sd3 * e1 - 36'sd3 * e2 + e3;
        case (func)
            FUNC_BSPLINE: begin
                k.k0 = cubic;
                k.k1 = 36'sd3 * e0 - 36'sd6 * e1 + 36'sd3 * e2;
                k.k2 = 36'sd3 * e2 - 36'sd3 * e0;
                k.k3 = e0 + 36'sd4 * e1 + e2;
            end
            FUNC_CATMULL_ROM: begin
                k.k0 = cubic;
                k.k1 = 36'sd2 * e0 - 36'sd5 * e1 + 36'sd4 * e2 - e3;
                k.k2 = e2 - e0;
                k.k3 = 36'sd2 * e1;
            end
            FUNC_BEZIER: begin
                k.k0 = cubic;
                k.k1 = 36'sd3 * e0 - 36'sd6 * e1 + 36'sd3 * e2;
                k.k2 = 36'sd3 * e1 - 36'sd3 * e0;
                k.k3 = e0;
            end
            FUNC_TANGENT: begin
                k.k0 = '0;
                k.k1 = cubic;
                k.k2 = 36'sd2 * e0 - 36'sd4 * e1 + 36'sd2 * e2;
                k.k3 = e1 - e0;
            end
            default: begin
                k = '0;
            end
        endcase
        return k;
    endfunction

endpackage

// ----- design/cce_coef.sv -----
// ----------------------------------------------------------------------------
// Coefficient stage
// Forms the polynomial coefficients from the control values and clamps t.
// ----------------------------------------------------------------------------
module cce_coef
    import cce_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  func_t               in_func,
    input  ctrl_t               in_ctrl_0,
    input  ctrl_t               in_ctrl_1,
    input  ctrl_t               in_ctrl_2,
    input  ctrl_t               in_ctrl_3,
    input  logic [T_IN_W-1:0]   in_param_t,
    output logic                out_valid,
    input  logic                out_ready,
    output side_t               out_side,
    output logic [FRAC_BITS:0]  out_t
);

    localparam int CMP_W = (FRAC_BITS + 2 > T_IN_W) ? FRAC_BITS + 2 : T_IN_W;
    localparam logic [CMP_W-1:0] T_ONE = CMP_W'(1) << FRAC_BITS;

    logic                valid_reg;
    side_t               side_reg;
    side_t               side_next;
    logic [FRAC_BITS:0]  t_reg;
    logic [FRAC_BITS:0]  t_next;
    logic [CMP_W-1:0]    t_wide;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        t_wide          = CMP_W'(in_param_t);
        // t above one counts as one
        t_next          = (t_wide > T_ONE) ? T_ONE[FRAC_BITS:0] : t_wide[FRAC_BITS:0];
        side_next.coefs = curve_coefs(in_func, in_ctrl_0, in_ctrl_1, in_ctrl_2, in_ctrl_3);
        side_next.func  = in_func;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            side_reg <= side_next;
            t_reg    <= t_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_t     = t_reg;

endmodule

// ----- design/cce_hstep.sv -----
// ----------------------------------------------------------------------------
// Horner step
// One multiply by t, then round to nearest and add the next coefficient.
// ----------------------------------------------------------------------------
module cce_hstep
    import cce_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  acc_t                in_acc,
    input  coef_t               in_k,
    input  logic [FRAC_BITS:0]  in_t,
    input  side_t               in_side,
    output logic                out_valid,
    input  logic                out_ready,
    output acc_t                out_acc,
    output logic [FRAC_BITS:0]  out_t,
    output side_t               out_side
);

    localparam int P_W = ACC_W + FRAC_BITS + 2;
    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(1) << (FRAC_BITS - 1);

    logic                    mul_v_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [P_W-1:0]   prod_next;
    coef_t                   mul_k_reg;
    logic [FRAC_BITS:0]      mul_t_reg;
    side_t                   mul_side_reg;

    logic                    add_v_reg;
    acc_t                    acc_reg;
    acc_t                    acc_next;
    logic [FRAC_BITS:0]      add_t_reg;
    side_t                   add_side_reg;

    logic signed [P_W-1:0]   acc_ext;
    logic signed [P_W-1:0]   t_ext;
    logic signed [P_W-1:0]   rounded;
    logic                    mul_ready;
    logic                    add_ready;

    assign add_ready = !add_v_reg || out_ready;
    assign mul_ready = !mul_v_reg || add_ready;
    assign in_ready  = mul_ready;

    always_comb begin
        acc_ext   = P_W'(in_acc);
        t_ext     = P_W'({1'b0, in_t});
        prod_next = acc_ext * t_ext;
        // nearest, ties towards plus infinity
        rounded   = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
        acc_next  = rounded[ACC_W-1:0] + ACC_W'(mul_k_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
            add_v_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_v_reg <= in_valid;
            end
            if (add_ready) begin
                add_v_reg <= mul_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && mul_ready) begin
            prod_reg     <= prod_next;
            mul_k_reg    <= in_k;
            mul_t_reg    <= in_t;
            mul_side_reg <= in_side;
        end
        if (mul_v_reg && add_ready) begin
            acc_reg      <= acc_next;
            add_t_reg    <= mul_t_reg;
            add_side_reg <= mul_side_reg;
        end
    end

    assign out_valid = add_v_reg;
    assign out_acc   = acc_reg;
    assign out_t     = add_t_reg;
    assign out_side  = add_side_reg;

endmodule

// ----- design/cce_div.sv -----
// ----------------------------------------------------------------------------
// Final divide and saturate
// Divides by the curve's denominator with rounding, clips to 32 bits.
// ----------------------------------------------------------------------------
module cce_div
    import cce_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  acc_t               in_acc,
    input  func_t              in_func,
    output logic               out_valid,
    input  logic               out_ready,
    output ctrl_t              out_value,
    output logic               out_sat
);

    localparam logic signed [U_W-1:0] BSPL_BIAS = 3;
    localparam logic signed [U_W-1:0] CR_BIAS   = 1;
    localparam logic [U_HI_W-1:0]     REM_H_LIM = 3;
    localparam logic [V_W-1:0]        REM_L_LIM = 3;

    // stage 1: halve with rounding bias for B-spline and Catmull-Rom
    logic                    s1_v_reg;
    acc_t                    y1_reg;
    acc_t                    y1_next;
    logic                    d1_reg;
    logic signed [U_W-1:0]   acc_wide;
    logic signed [U_W-1:0]   biased;

    // stage 2: high half times reciprocal
    logic                    s2_v_reg;
    logic [MH_W-1:0]         mh_reg;
    logic [MH_W-1:0]         mh_next;
    logic [U_W-1:0]          u2_reg;
    logic [U_W-1:0]          u_next;
    acc_t                    y2_reg;
    logic                    d2_reg;

    // stage 3: high quotient and remainder
    logic                    s3_v_reg;
    logic [QH_W-1:0]         qh3_reg;
    logic [QH_W-1:0]         qh_next;
    logic [V_W-1:0]          v3_reg;
    logic [V_W-1:0]          v_next;
    acc_t                    y3_reg;
    logic                    d3_reg;
    logic [QH_W-1:0]         qh_est;
    logic [U_HI_W-1:0]       rem_h;

    // stage 4: low part times reciprocal
    logic                    s4_v_reg;
    logic [ML_W-1:0]         ml_reg;
    logic [ML_W-1:0]         ml_next;
    logic [QH_W-1:0]         qh4_reg;
    logic [V_W-1:0]          v4_reg;
    acc_t                    y4_reg;
    logic                    d4_reg;

    // stage 5: assemble, clip
    logic                    s5_v_reg;
    ctrl_t                   val_reg;
    ctrl_t                   val_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic [QL_W-1:0]         ql_est;
    logic [QL_W-1:0]         ql;
    logic [V_W-1:0]          rem_l;
    logic [U_W-1:0]          quot;
    logic signed [U_W-1:0]   full;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;
    logic s5_ready;

    assign s5_ready = !s5_v_reg || out_ready;
    assign s4_ready = !s4_v_reg || s5_ready;
    assign s3_ready = !s3_v_reg || s4_ready;
    assign s2_ready = !s2_v_reg || s3_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        acc_wide = U_W'(in_acc);
        case (in_func)
            FUNC_BSPLINE: begin
                biased  = acc_wide + BSPL_BIAS;
                y1_next = biased[ACC_W:1];
            end
            FUNC_CATMULL_ROM: begin
                biased  = acc_wide + CR_BIAS;
                y1_next = biased[ACC_W:1];
            end
            default: begin
                biased  = acc_wide;
                y1_next = in_acc;
            end
        endcase
    end

    always_comb begin
        // bias keeps the dividend positive and is a multiple of three
        u_next  = U_W'(y1_reg) + DIV3_BIAS;
        mh_next = MH_W'(u_next[U_W-1:U_LO_W]) * MH_W'(HI_RECIP);
    end

    always_comb begin
        qh_est  = mh_reg[MH_W-1:HI_SH];
        rem_h   = u2_reg[U_W-1:U_LO_W] - U_HI_W'({qh_est, 1'b0}) - U_HI_W'(qh_est);
        qh_next = qh_est;
        if (rem_h >= REM_H_LIM) begin
            qh_next = qh_est + QH_W'(1);
            rem_h   = rem_h - REM_H_LIM;
        end
        v_next  = {rem_h[1:0], u2_reg[U_LO_W-1:0]};
        ml_next = ML_W'(v3_reg) * ML_W'(LO_RECIP);
    end

    always_comb begin
        ql_est = ml_reg[ML_W-1:LO_SH];
        rem_l  = v4_reg - V_W'({ql_est, 1'b0}) - V_W'(ql_est);
        ql     = ql_est;
        if (rem_l >= REM_L_LIM) begin
            ql = ql_est + QL_W'(1);
        end
        quot = U_W'({qh4_reg, {U_LO_W{1'b0}}}) + U_W'(ql);
        if (d4_reg) begin
            full = $signed(quot) - DIV3_OFFSET;
        end else begin
            full = U_W'(y4_reg);
        end
        if (full > SAT_MAX) begin
            val_next = SAT_MAX[CTRL_W-1:0];
            sat_next = 1'b1;
        end else if (full < SAT_MIN) begin
            val_next = SAT_MIN[CTRL_W-1:0];
            sat_next = 1'b1;
        end else begin
            val_next = full[CTRL_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_v_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready) begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_ready) begin
                s4_v_reg <= s3_v_reg;
            end
            if (s5_ready) begin
                s5_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s1_ready) begin
            y1_reg <= y1_next;
            d1_reg <= (in_func == FUNC_BSPLINE);
        end
        if (s1_v_reg && s2_ready) begin
            mh_reg <= mh_next;
            u2_reg <= u_next;
            y2_reg <= y1_reg;
            d2_reg <= d1_reg;
        end
        if (s2_v_reg && s3_ready) begin
            qh3_reg <= qh_next;
            v3_reg  <= v_next;
            y3_reg  <= y2_reg;
            d3_reg  <= d2_reg;
        end
        if (s3_v_reg && s4_ready) begin
            ml_reg  <= ml_next;
            qh4_reg <= qh3_reg;
            v4_reg  <= v3_reg;
            y4_reg  <= y3_reg;
            d4_reg  <= d3_reg;
        end
        if (s4_v_reg && s5_ready) begin
            val_reg <= val_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = s5_v_reg;
    assign out_value = val_reg;
    assign out_sat   = sat_reg;

endmodule

// ----- design/cubic_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// Cubic curve evaluator
// Evaluates one scalar B-spline, Catmull-Rom, Bezier or Bezier tangent sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tuser selects the curve kind, s_tdata carries four signed
//   control values and the curve parameter t (t above one is taken as one).
//   Master channel: m_tdata is the rounded, clipped result; m_tuser flags a
//   result that was clipped. Evaluate a vector curve one coordinate a transfer.
//   An input transfer passes one coefficient stage, three Horner steps of
//   two stages each (multiply, then round and add), and five stages of
//   rounding division and clipping.
//   Throughput is one transfer per cycle while the receiver keeps taking
//   results; every stage is one register deep and holds its own valid bit.
//   A synchronous low on aresetn empties the pipeline. When the receiver
//   stalls, the pipeline keeps filling its empty stages and s_tready drops
//   only once every stage holds a sample; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cubic_curve_evaluator
    import cce_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ctrl_0 [31:0], ctrl_1 [63:32], ctrl_2 [95:64], ctrl_3 [127:96],
    // param_t [144:128], zero pad [151:145]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func [1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // value [31:0]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // saturated [0]
    output logic [0:0]            m_tuser
);

    logic                c_valid;
    logic                c_ready;
    side_t               c_side;
    logic [FRAC_BITS:0]  c_t;

    logic                h1_valid;
    logic                h1_ready;
    acc_t                h1_acc;
    logic [FRAC_BITS:0]  h1_t;
    side_t               h1_side;

    logic                h2_valid;
    logic                h2_ready;
    acc_t                h2_acc;
    logic [FRAC_BITS:0]  h2_t;
    side_t               h2_side;

    logic                h3_valid;
    logic                h3_ready;
    acc_t                h3_acc;
    side_t               h3_side;

    ctrl_t               res_value;
    logic                res_sat;

    cce_coef #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coef (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (func_t'(s_tuser)),
        .in_ctrl_0  (ctrl_t'(s_tdata[31:0])),
        .in_ctrl_1  (ctrl_t'(s_tdata[63:32])),
        .in_ctrl_2  (ctrl_t'(s_tdata[95:64])),
        .in_ctrl_3  (ctrl_t'(s_tdata[127:96])),
        .in_param_t (s_tdata[144:128]),
        .out_valid  (c_valid),
        .out_ready  (c_ready),
        .out_side   (c_side),
        .out_t      (c_t)
    );

    cce_hstep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hstep_1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_acc    (ACC_W'(c_side.coefs.k0)),
        .in_k      (c_side.coefs.k1),
        .in_t      (c_t),
        .in_side   (c_side),
        .out_valid (h1_valid),
        .out_ready (h1_ready),
        .out_acc   (h1_acc),
        .out_t     (h1_t),
        .out_side  (h1_side)
    );

    cce_hstep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hstep_2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h1_valid),
        .in_ready  (h1_ready),
        .in_acc    (h1_acc),
        .in_k      (h1_side.coefs.k2),
        .in_t      (h1_t),
        .in_side   (h1_side),
        .out_valid (h2_valid),
        .out_ready (h2_ready),
        .out_acc   (h2_acc),
        .out_t     (h2_t),
        .out_side  (h2_side)
    );

    cce_hstep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hstep_3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h2_valid),
        .in_ready  (h2_ready),
        .in_acc    (h2_acc),
        .in_k      (h2_side.coefs.k3),
        .in_t      (h2_t),
        .in_side   (h2_side),
        .out_valid (h3_valid),
        .out_ready (h3_ready),
        .out_acc   (h3_acc),
        .out_t     (),
        .out_side  (h3_side)
    );

    cce_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h3_valid),
        .in_ready  (h3_ready),
        .in_acc    (h3_acc),
        .in_func   (h3_side.func),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (res_value),
        .out_sat   (res_sat)
    );

    assign m_tdata    = res_value;
    assign m_tuser[0] = res_sat;

endmodule

// ----- design/cce_checker.sv -----
// ----------------------------------------------------------------------------
// Cubic curve evaluator port checker
// Watches the stream ports of the evaluator over time.
// ----------------------------------------------------------------------------
module cce_checker
    import cce_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]            m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // an empty or draining output stage lets the whole pipe advance
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled while output can move");

    // a clipped result sits on a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("saturation flag on an unclipped value");

endmodule

bind cubic_curve_evaluator cce_checker u_cce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
